// ===== src/psgseq_pkg.sv =====
package psgseq_pkg;

  // Channel count; the last channel is the noise channel
  localparam int CHANNELS  = 4;
  localparam int CH_W      = $clog2(CHANNELS);
  localparam int NOISE_CH  = CHANNELS - 1;
  localparam int TONE_LAST = CHANNELS - 2;

  localparam int V2_LEN = 67;
  localparam int V3_LEN = 77;

  localparam logic [7:0]  ENV_OFF    = 8'hFF;
  localparam logic [15:0] DUR_END    = 16'hFFFF;
  localparam logic [3:0]  ATT_SILENT = 4'hF;
  localparam logic [10:0] NOISE_R0   = 11'd32;
  localparam logic [10:0] NOISE_R1   = 11'd64;
  localparam logic [10:0] NOISE_R2   = 11'd128;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_RECORD = 2'd1,
    KIND_TICK   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_TONE    = 2'd0,
    ST_ENDED   = 2'd1,
    ST_NO_NOTE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    GEN_SQUARE      = 2'd0,
    GEN_PERIODIC    = 2'd1,
    GEN_NOISE_WHITE = 2'd2
  } gen_t;

  typedef enum logic [1:0] {
    REG_DISSOLVE_MODE = 2'd0,
    REG_ADD_VOLUME    = 2'd1,
    REG_GAME_VOLUME   = 2'd2,
    REG_SOUND_ON      = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DM_OFF = 2'd0,
    DM_V3A = 2'd1,
    DM_V2  = 2'd2,
    DM_V3B = 2'd3
  } dmode_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  channel;
    logic [15:0] duration;
    logic [7:0]  freq_high_byte;
    logic [7:0]  freq_low_byte;
    logic [7:0]  volume_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_channel;
    logic [1:0]  status;
    logic [10:0] frequency;
    logic [3:0]  attenuation;
    logic [1:0]  wave_type;
    logic        need_record;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_tick;
  } dp_sts_t;

  // Dissolve envelope tables
  localparam logic signed [4:0] DIS_V2 [V2_LEN] = '{
    -5'sd2, -5'sd3, -5'sd2, -5'sd1, 5'sd0, 5'sd0, 5'sd1, 5'sd1, 5'sd1,
    5'sd1, 5'sd2, 5'sd2, 5'sd2, 5'sd2, 5'sd2, 5'sd2, 5'sd2,
    5'sd2, 5'sd3, 5'sd3, 5'sd3, 5'sd3, 5'sd3, 5'sd3, 5'sd3,
    5'sd4, 5'sd4, 5'sd4, 5'sd4, 5'sd5, 5'sd5, 5'sd5, 5'sd5,
    5'sd6, 5'sd6, 5'sd6, 5'sd6, 5'sd6, 5'sd7, 5'sd7, 5'sd7,
    5'sd7, 5'sd8, 5'sd8, 5'sd8, 5'sd8, 5'sd9, 5'sd9, 5'sd9,
    5'sd9, 5'sd10, 5'sd10, 5'sd10, 5'sd10, 5'sd11, 5'sd11, 5'sd11,
    5'sd11, 5'sd11, 5'sd11, 5'sd12, 5'sd12, 5'sd12, 5'sd12, 5'sd12,
    5'sd12, 5'sd13
  };

  localparam logic signed [4:0] DIS_V3 [V3_LEN] = '{
    -5'sd2, -5'sd3, -5'sd2, -5'sd1,
    5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0,
    5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1,
    5'sd2, 5'sd2, 5'sd2, 5'sd2, 5'sd2, 5'sd2, 5'sd2, 5'sd2, 5'sd2, 5'sd2,
    5'sd3, 5'sd3, 5'sd3, 5'sd3, 5'sd3, 5'sd3, 5'sd3, 5'sd3,
    5'sd4, 5'sd4, 5'sd4, 5'sd4, 5'sd4,
    5'sd5, 5'sd5, 5'sd5, 5'sd5, 5'sd5,
    5'sd6, 5'sd6, 5'sd6, 5'sd6, 5'sd6,
    5'sd7, 5'sd7, 5'sd7, 5'sd7,
    5'sd8, 5'sd8, 5'sd8, 5'sd8,
    5'sd9, 5'sd9, 5'sd9, 5'sd9,
    5'sd10, 5'sd10, 5'sd10, 5'sd10,
    5'sd11, 5'sd11, 5'sd11, 5'sd11, 5'sd11, 5'sd11,
    5'sd12, 5'sd12, 5'sd12, 5'sd12, 5'sd12, 5'sd12,
    5'sd13
  };

  // Look up one envelope step; entries past the table read as zero
  function automatic logic signed [4:0] dis_step(input logic use_v2, input logic [6:0] idx);
    logic signed [4:0] v;
    v = 5'sd0;
    if (use_v2) begin
      if (idx < 7'(V2_LEN)) v = DIS_V2[idx];
    end else if (idx < 7'(V3_LEN)) begin
      v = DIS_V3[idx];
    end
    return v;
  endfunction

endpackage

// ===== src/psg_note_sequencer_with_dissolve.sv =====
// Four-channel note sequencer with dissolve envelope for a tone-plus-noise
// sound chip (channels 0..2 square tone, channel 3 noise).
// Input channel (in_valid / in_stall / in_data): start, note record or tick
// transactions. Only a tick produces a transaction on the result channel
// (out_valid / out_stall / out_data); start and record produce none.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data) is
// always ready; the user must write it only while the block is idle, as
// the block itself does not enforce this. A new input item is taken only
// after the previous one has executed: the controller takes an item in its
// idle state and runs it through the per-channel register file and the
// dissolve table in its execute state. A tick result appears on out_valid
// the cycle after it executes. If the receiver stalls, the result register
// holds; start and record items keep executing, while a tick waits in the
// execute step, with in_stall high, until the held result is taken.
// Synchronous reset (rst_n low) clears all channels to inactive, silent,
// envelope off, and loads dissolve_mode 3, add_volume 0, game_volume 0
// and sound_on 1.
module psg_note_sequencer_with_dissolve (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  psgseq_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output psgseq_pkg::out_item_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_data
);
  import psgseq_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  assign cfg_ready = 1'b1;

  psgseq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  psgseq_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data),
    .cfg_we_i    (cfg_valid && cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .out_data_o  (out_data)
  );

endmodule

// ===== src/psgseq_ctrl.sv =====
module psgseq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output psgseq_pkg::ctrl_cmd_t cmd_o,
  input  psgseq_pkg::dp_sts_t   sts_i
);
  import psgseq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_issue;

  // Busy while an item is held
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // A tick may only run once the result register is free or draining
  assign can_issue = !sts_i.is_tick || !out_valid_r || !out_stall;

  // Sequence the commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd_o         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (can_issue) begin
          cmd_o.exec = 1'b1;
          state_nxt  = S_IDLE;
          if (sts_i.is_tick) out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted but controller not busy");

  a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_o.exec && sts_i.is_tick) |=> out_valid)
    else $error("tick executed without raising result valid");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && sts_i.is_tick && out_valid && out_stall) |=> state_r == S_EXEC)
    else $error("tick left execute while result still waiting");

  a_rise_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd_o.exec))
    else $error("result valid raised without an executed tick");

endmodule

// ===== src/psgseq_dp.sv =====
module psgseq_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  psgseq_pkg::ctrl_cmd_t cmd_i,
  output psgseq_pkg::dp_sts_t   sts_o,
  input  psgseq_pkg::in_item_t  in_data_i,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [7:0]            cfg_data_i,
  output psgseq_pkg::out_item_t out_data_o
);
  import psgseq_pkg::*;

  // Configuration registers
  logic [1:0] dmode_r;
  logic       add_vol_r;
  logic [7:0] gvol_r;
  logic       sound_on_r;

  // Held item and result
  in_item_t  item_r;
  out_item_t res_r, res_nxt;

  // Per-channel state
  logic [15:0] rem_r  [CHANNELS];
  logic [15:0] rem_nxt[CHANNELS];
  logic [7:0]  env_r  [CHANNELS];
  logic [7:0]  env_nxt[CHANNELS];
  logic [3:0]  base_r  [CHANNELS];
  logic [3:0]  base_nxt[CHANNELS];
  logic [3:0]  last_r  [CHANNELS];
  logic [3:0]  last_nxt[CHANNELS];
  logic [10:0] div_r  [CHANNELS];
  logic [10:0] div_nxt[CHANNELS];
  logic [1:0]  gen_r  [CHANNELS];
  logic [1:0]  gen_nxt[CHANNELS];
  logic        act_r  [CHANNELS];
  logic        act_nxt[CHANNELS];

  logic [CH_W-1:0]   ch;
  logic              ch_ok, is_noise;
  logic [15:0]       cur_rem;
  logic [7:0]        cur_env;
  logic [3:0]        cur_base, cur_last;
  logic              use_v2, env_past;
  logic signed [4:0] step;
  logic signed [5:0] sum6;
  logic [3:0]        dis4, vsat, a_pre, atten;
  logic [8:0]        vsum;
  logic [10:0]       noise_div;

  assign sts_o.is_tick = (item_r.kind == KIND_TICK);
  assign out_data_o    = res_r;

  // Decode the addressed channel
  assign ch       = item_r.channel[CH_W-1:0];
  assign ch_ok    = ({1'b0, item_r.channel} < 3'(CHANNELS));
  assign is_noise = (ch == CH_W'(NOISE_CH));
  assign cur_rem  = rem_r[ch];
  assign cur_env  = env_r[ch];
  assign cur_base = base_r[ch];
  assign cur_last = last_r[ch];

  // Dissolve step: table add, clamp, volume offset, low boost
  assign use_v2   = (dmode_r == DM_V2);
  assign env_past = use_v2 ? (cur_env >= 8'(V2_LEN)) : (cur_env >= 8'(V3_LEN));
  assign step     = dis_step(use_v2, cur_env[6:0]);
  assign sum6     = $signed({2'b00, cur_base}) + $signed({step[4], step});

  always_comb begin
    if (sum6 < 6'sd0)       dis4 = 4'd0;
    else if (sum6 > 6'sd15) dis4 = 4'd15;
    else                    dis4 = sum6[3:0];
    vsum = {5'b0, dis4} + {1'b0, gvol_r};
    if (!add_vol_r)         vsat = dis4;
    else if (vsum > 9'd15)  vsat = 4'd15;
    else                    vsat = vsum[3:0];
    if (cur_base == ATT_SILENT) a_pre = ATT_SILENT;
    else if (cur_env == ENV_OFF) a_pre = cur_base;
    else if (env_past)           a_pre = cur_last;
    else                         a_pre = vsat;
    atten = (a_pre < 4'd8) ? a_pre + 4'd2 : a_pre;
  end

  // Noise rate select
  always_comb begin
    case (item_r.freq_low_byte[1:0])
      2'd0:    noise_div = NOISE_R0;
      2'd1:    noise_div = NOISE_R1;
      2'd2:    noise_div = NOISE_R2;
      default: noise_div = {div_r[TONE_LAST][9:0], 1'b0};
    endcase
  end

  // Execute the held item
  always_comb begin
    rem_nxt  = rem_r;
    env_nxt  = env_r;
    base_nxt = base_r;
    last_nxt = last_r;
    div_nxt  = div_r;
    gen_nxt  = gen_r;
    act_nxt  = act_r;
    res_nxt  = '{out_channel: item_r.channel, status: ST_ENDED, frequency: '0,
                 attenuation: ATT_SILENT, wave_type: GEN_SQUARE, need_record: 1'b0};
    case (item_r.kind)
      KIND_START: begin
        for (int k = 0; k < CHANNELS; k++) begin
          rem_nxt[k] = '0;
          env_nxt[k] = ENV_OFF;
          div_nxt[k] = '0;
          act_nxt[k] = 1'b1;
        end
      end
      KIND_RECORD: begin
        if (ch_ok && act_r[ch] && cur_rem == '0) begin
          rem_nxt[ch] = item_r.duration;
          if (item_r.duration != '0 && item_r.duration != DUR_END) begin
            if (!is_noise && dmode_r != DM_OFF) env_nxt[ch] = '0;
            base_nxt[ch] = item_r.volume_byte[3:0];
            if (!is_noise) begin
              div_nxt[ch] = {item_r.freq_high_byte[5:0], item_r.freq_low_byte[3:0]};
              gen_nxt[ch] = GEN_SQUARE;
            end else begin
              div_nxt[ch] = noise_div;
              gen_nxt[ch] = item_r.freq_low_byte[2] ? GEN_NOISE_WHITE : GEN_PERIODIC;
            end
          end
        end
      end
      KIND_TICK: begin
        if (sound_on_r && ch_ok && act_r[ch]) begin
          if (cur_rem == '0) begin
            res_nxt.status      = ST_NO_NOTE;
            res_nxt.need_record = 1'b1;
          end else if (cur_rem == DUR_END) begin
            act_nxt[ch]  = 1'b0;
            base_nxt[ch] = ATT_SILENT;
            last_nxt[ch] = ATT_SILENT;
          end else begin
            res_nxt.status      = ST_TONE;
            res_nxt.frequency   = div_r[ch];
            res_nxt.attenuation = atten;
            res_nxt.wave_type   = gen_r[ch];
            res_nxt.need_record = (cur_rem == 16'd1);
            rem_nxt[ch]         = cur_rem - 16'd1;
            // Advance or stop the envelope
            if (cur_base != ATT_SILENT && cur_env != ENV_OFF) begin
              if (env_past) begin
                env_nxt[ch]  = ENV_OFF;
                base_nxt[ch] = cur_last;
              end else begin
                env_nxt[ch]  = cur_env + 8'd1;
                last_nxt[ch] = dis4;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Capture the item and the result
  always_ff @(posedge clk) begin
    if (cmd_i.load) item_r <= in_data_i;
    if (cmd_i.exec && sts_o.is_tick) res_r <= res_nxt;
  end

  // Hold configuration and channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dmode_r    <= DM_V3B;
      add_vol_r  <= 1'b0;
      gvol_r     <= '0;
      sound_on_r <= 1'b1;
      for (int k = 0; k < CHANNELS; k++) begin
        rem_r[k]  <= '0;
        env_r[k]  <= ENV_OFF;
        base_r[k] <= ATT_SILENT;
        last_r[k] <= ATT_SILENT;
        div_r[k]  <= '0;
        gen_r[k]  <= GEN_SQUARE;
        act_r[k]  <= 1'b0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_DISSOLVE_MODE: dmode_r    <= cfg_data_i[1:0];
          REG_ADD_VOLUME:    add_vol_r  <= cfg_data_i[0];
          REG_GAME_VOLUME:   gvol_r     <= cfg_data_i;
          REG_SOUND_ON:      sound_on_r <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.exec) begin
        rem_r  <= rem_nxt;
        env_r  <= env_nxt;
        base_r <= base_nxt;
        last_r <= last_nxt;
        div_r  <= div_nxt;
        gen_r  <= gen_nxt;
        act_r  <= act_nxt;
      end
    end
  end

endmodule
